[rtl/assert_macros.svh]
// assertion helpers for the rtl files (included by stt_ctrl)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, cond)

`endif

`endif

[rtl/stt_pkg.sv]
`default_nettype none

package stt_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int MAX_RESULTS    = 8;
    localparam int CNT_W          = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        ACT_TICK   = 3'd0,
        ACT_CREATE = 3'd1,
        ACT_START  = 3'd2,
        ACT_STOP   = 3'd3,
        ACT_ATTACH = 3'd4,
        ACT_DETACH = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        STS_OK          = 3'd0,
        STS_INVALID     = 3'd1,
        STS_RUNNING     = 3'd2,
        STS_NOT_RUNNING = 3'd3,
        STS_NO_FREE     = 3'd4
    } status_t;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_RD,
        ST_EX,
        ST_FLUSH
    } state_t;

    // write side of the interval and elapsed stores
    typedef struct packed {
        logic        ivl_we;
        logic        el_we;
        logic [31:0] ivl_wdata;
        logic [31:0] el_wdata;
    } mem_wr_t;

endpackage

`default_nettype wire

[rtl/stt_alu.sv]
`default_nettype none

module stt_alu
    import stt_pkg::*;
(
    input  wire logic [31:0] elapsed,
    input  wire logic [31:0] tick,
    input  wire logic [31:0] interval,
    output logic      [31:0] sum,
    output logic             hit
);

    // elapsed wraps modulo 2^32
    assign sum = elapsed + tick;
    assign hit = (sum >= interval);

endmodule

`default_nettype wire

[rtl/stt_mem.sv]
`default_nettype none

module stt_mem
    import stt_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  wire logic             aclk,
    input  wire logic [IDX_W-1:0] addr,
    input  wire mem_wr_t          wr,
    output logic      [31:0]      ivl_q,
    output logic      [31:0]      el_q
);

    logic [31:0] ivl_mem [SLOT_COUNT];
    logic [31:0] el_mem  [SLOT_COUNT];

    always_ff @(posedge aclk) begin
        if (wr.ivl_we) begin
            ivl_mem[addr] <= wr.ivl_wdata;
        end
        ivl_q <= ivl_mem[addr];
    end

    always_ff @(posedge aclk) begin
        if (wr.el_we) begin
            el_mem[addr] <= wr.el_wdata;
        end
        el_q <= el_mem[addr];
    end

endmodule

`default_nettype wire

[rtl/stt_ctrl.sv]
`default_nettype none

`include "assert_macros.svh"

module stt_ctrl
    import stt_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [2:0]       s_action,
    input  wire logic [7:0]       s_timer_id,
    input  wire logic [31:0]      s_interval_ms,
    input  wire logic [31:0]      s_tick_count,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic                  m_kind,
    output logic      [2:0]       m_status,
    output logic      [5:0]       m_slot,
    output logic                  m_last,
    output logic      [IDX_W-1:0] mem_addr,
    output mem_wr_t               mem_wr,
    output logic      [31:0]      alu_tick,
    input  wire logic [31:0]      alu_sum,
    input  wire logic             alu_hit
);

    state_t state_reg, state_next;

    logic [2:0]            act_reg;
    logic [7:0]            id_reg;
    logic [31:0]           ivl_reg;
    logic [31:0]           tick_reg;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]      pend_slot_reg, pend_slot_next;
    logic [SLOT_COUNT-1:0] running_reg, running_next;
    logic [SLOT_COUNT-1:0] notify_reg, notify_next;
    logic [SLOT_COUNT-1:0] used_reg, used_next;

    logic                  out_valid_reg;
    logic                  out_kind_reg;
    logic [2:0]            out_status_reg;
    logic [5:0]            out_slot_reg;
    logic                  out_last_reg;

    logic                  push;
    logic                  push_kind;
    logic [2:0]            push_status;
    logic [5:0]            push_slot;
    logic                  push_last;

    logic                  in_fire;
    logic                  out_free;
    logic                  id_ok;
    logic [IDX_W-1:0]      id_idx;
    logic                  free_found;
    logic [IDX_W-1:0]      free_idx;
    logic                  run;
    logic                  expired;
    logic                  event_hit;
    logic                  ex_go;
    logic                  last_slot;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign alu_tick = tick_reg;

    assign id_ok  = (id_reg < 8'(SLOT_COUNT));
    assign id_idx = id_reg[IDX_W-1:0];

    // lowest slot whose used bit is clear
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign run       = running_reg[idx_reg];
    assign expired   = run && used_reg[idx_reg] && alu_hit;
    assign event_hit = expired && notify_reg[idx_reg] && (cnt_reg < CNT_W'(MAX_RESULTS));
    // a new event flushes the held one, which needs room on the result side
    assign ex_go     = !(event_hit && pend_valid_reg) || out_free;
    assign last_slot = (idx_reg == IDX_W'(SLOT_COUNT - 1));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    case (s_action)
                        ACT_TICK: begin
                            state_next = (s_tick_count != 32'd0) ? ST_RD : ST_IDLE;
                        end
                        ACT_CREATE, ACT_START, ACT_STOP, ACT_ATTACH, ACT_DETACH: begin
                            state_next = ST_CMD;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CMD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD: begin
                state_next = ST_EX;
            end
            ST_EX: begin
                if (ex_go) begin
                    state_next = last_slot ? ST_FLUSH : ST_RD;
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        mem_addr        = idx_reg;
        mem_wr          = '0;
        push            = 1'b0;
        push_kind       = KIND_STATUS;
        push_status     = STS_OK;
        push_slot       = '0;
        push_last       = 1'b1;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        running_next    = running_reg;
        notify_next     = notify_reg;
        used_next       = used_reg;
        case (state_reg)
            ST_IDLE: begin
                idx_next        = '0;
                cnt_next        = '0;
                pend_valid_next = 1'b0;
            end
            ST_CMD: begin
                mem_addr = (act_reg == ACT_CREATE) ? free_idx : id_idx;
                if (out_free) begin
                    push = 1'b1;
                    case (act_reg)
                        ACT_CREATE: begin
                            if (free_found) begin
                                mem_wr.ivl_we       = 1'b1;
                                mem_wr.ivl_wdata    = ivl_reg;
                                mem_wr.el_we        = 1'b1;
                                mem_wr.el_wdata     = '0;
                                used_next[free_idx] = (ivl_reg != 32'd0);
                                push_slot           = 6'(free_idx);
                            end else begin
                                push_status = STS_NO_FREE;
                            end
                        end
                        ACT_START: begin
                            if (!id_ok) begin
                                push_status = STS_INVALID;
                            end else if (running_reg[id_idx]) begin
                                push_status = STS_RUNNING;
                            end else begin
                                running_next[id_idx] = 1'b1;
                                mem_wr.el_we         = 1'b1;
                                mem_wr.el_wdata      = '0;
                            end
                        end
                        ACT_STOP: begin
                            if (!id_ok) begin
                                push_status = STS_INVALID;
                            end else if (!running_reg[id_idx]) begin
                                push_status = STS_NOT_RUNNING;
                            end else begin
                                running_next[id_idx] = 1'b0;
                            end
                        end
                        ACT_ATTACH: begin
                            if (!id_ok) begin
                                push_status = STS_INVALID;
                            end else begin
                                notify_next[id_idx] = 1'b1;
                            end
                        end
                        ACT_DETACH: begin
                            if (!id_ok) begin
                                push_status = STS_INVALID;
                            end else begin
                                notify_next[id_idx] = 1'b0;
                            end
                        end
                        default: begin
                            push = 1'b0;
                        end
                    endcase
                end
            end
            ST_RD: begin
                mem_addr = idx_reg;
            end
            ST_EX: begin
                if (ex_go) begin
                    if (run) begin
                        mem_wr.el_we    = 1'b1;
                        mem_wr.el_wdata = expired ? 32'd0 : alu_sum;
                    end
                    if (event_hit) begin
                        cnt_next        = cnt_reg + 1'b1;
                        pend_valid_next = 1'b1;
                        pend_slot_next  = idx_reg;
                        if (pend_valid_reg) begin
                            push        = 1'b1;
                            push_kind   = KIND_EXPIRY;
                            push_slot   = 6'(pend_slot_reg);
                            push_last   = 1'b0;
                        end
                    end
                    if (!last_slot) begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (pend_valid_reg && out_free) begin
                    push            = 1'b1;
                    push_kind       = KIND_EXPIRY;
                    push_slot       = 6'(pend_slot_reg);
                    push_last       = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default: begin
                pend_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            running_reg    <= '0;
            notify_reg     <= '0;
            used_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            running_reg    <= running_next;
            notify_reg     <= notify_next;
            used_reg       <= used_next;
            if (push) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        pend_slot_reg <= pend_slot_next;
        if (in_fire) begin
            act_reg  <= s_action;
            id_reg   <= s_timer_id;
            ivl_reg  <= s_interval_ms;
            tick_reg <= s_tick_count;
        end
        if (push) begin
            out_kind_reg   <= push_kind;
            out_status_reg <= push_status;
            out_slot_reg   <= push_slot;
            out_last_reg   <= push_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_kind   = out_kind_reg;
    assign m_status = out_status_reg;
    assign m_slot   = out_slot_reg;
    assign m_last   = out_last_reg;

    `ASSERT_PROP(a_ready_no_pend, aclk, aresetn, s_tready |-> !pend_valid_reg)
    `ASSERT_PROP(a_pend_in_walk, aclk, aresetn,
        pend_valid_reg |-> (state_reg == ST_RD || state_reg == ST_EX || state_reg == ST_FLUSH))
    `ASSERT_NEVER(a_push_overrun, aclk, aresetn, push && !out_free)
    `ASSERT_NEVER(a_cnt_range, aclk, aresetn, cnt_reg > CNT_W'(MAX_RESULTS))
    `ASSERT_PROP(a_flush_last, aclk, aresetn,
        (state_reg == ST_FLUSH && push) |=> (m_tvalid && m_last && m_kind == KIND_EXPIRY))

endmodule

`default_nettype wire

[rtl/software_timer_table.sv]
`default_nettype none

// Table of SLOT_COUNT interval timers driven by tick, create, start, stop, attach and
// detach transactions. s_tready is high only while the block is idle, so one transaction
// is in work at a time; a finished result waits in the output register and does not hold
// off the next input. A command (create, start, stop, attach, detach) is held in ST_CMD
// while an earlier result still waits on the result channel. A nonzero tick visits
// every slot through one shared 32-bit adder and compare, each slot taking a registered
// read of the interval and elapsed stores (ST_RD) and then an update (ST_EX); the walk
// can stall while the result channel is busy. A zero tick and unused action codes go
// straight back to idle and give no result. Up to eight expiry events are sent per tick
// in rising slot order; the last result of every transaction that gives one carries
// m_tlast. There is no clearing pass after reset.
module software_timer_table
    import stt_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] timer_id, [39:8] interval_ms, [71:40] tick_count
    input  wire logic [71:0] s_tdata,
    // [2:0] action
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [2:0] status, [8:3] slot, [15:9] zero
    output logic      [15:0] m_tdata,
    // [0] kind
    output logic      [0:0]  m_tuser,
    output logic             m_tlast
);

    logic [IDX_W-1:0] mem_addr;
    mem_wr_t          mem_wr;
    logic [31:0]      ivl_q;
    logic [31:0]      el_q;
    logic [31:0]      alu_tick;
    logic [31:0]      alu_sum;
    logic             alu_hit;
    logic             m_kind;
    logic [2:0]       m_status;
    logic [5:0]       m_slot;

    stt_ctrl #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_action      (s_tuser),
        .s_timer_id    (s_tdata[7:0]),
        .s_interval_ms (s_tdata[39:8]),
        .s_tick_count  (s_tdata[71:40]),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_kind        (m_kind),
        .m_status      (m_status),
        .m_slot        (m_slot),
        .m_last        (m_tlast),
        .mem_addr      (mem_addr),
        .mem_wr        (mem_wr),
        .alu_tick      (alu_tick),
        .alu_sum       (alu_sum),
        .alu_hit       (alu_hit)
    );

    stt_mem #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_mem (
        .aclk  (aclk),
        .addr  (mem_addr),
        .wr    (mem_wr),
        .ivl_q (ivl_q),
        .el_q  (el_q)
    );

    stt_alu u_alu (
        .elapsed  (el_q),
        .tick     (alu_tick),
        .interval (ivl_q),
        .sum      (alu_sum),
        .hit      (alu_hit)
    );

    assign m_tdata = {7'd0, m_slot, m_status};
    assign m_tuser = m_kind;

endmodule

`default_nettype wire

[test/stt_checker.sv]
`timescale 1ns / 1ps

module stt_checker
    import stt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    // [7:0] timer_id, [39:8] interval_ms, [71:40] tick_count
    input  wire logic [71:0] s_tdata,
    // [2:0] action
    input  wire logic [2:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    // [2:0] status, [8:3] slot, [15:9] zero
    input  wire logic [15:0] m_tdata,
    // [0] kind
    input  wire logic [0:0]  m_tuser,
    input  wire logic        m_tlast,
    output int               mismatches,
    output int               outstanding,
    output int               expiries_seen,
    output int               statuses_seen
);

    typedef struct packed {
        logic       kind;
        status_t    status;
        logic [5:0] slot;
        logic       last;
    } timer_result_t;

    logic [31:0]   period_tbl  [SLOT_COUNT_DEF];
    logic [31:0]   elapsed_tbl [SLOT_COUNT_DEF];
    bit            run_on      [SLOT_COUNT_DEF];
    bit            notify_on   [SLOT_COUNT_DEF];
    timer_result_t due_q[$];

    task automatic advance_timers(input logic [2:0] act, input logic [7:0] id,
                                  input logic [31:0] ivl, input logic [31:0] ms);
        timer_result_t batch[$];
        timer_result_t r;
        int            fired;
        bit            found;
        fired = 0;
        found = 0;
        r = '0;
        case (act)
            ACT_TICK: begin
                if (ms != 0) begin
                    for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
                        if (run_on[i]) begin
                            elapsed_tbl[i] = elapsed_tbl[i] + ms;
                            if (period_tbl[i] != 0 && elapsed_tbl[i] >= period_tbl[i]) begin
                                elapsed_tbl[i] = '0;
                                // events beyond the per-tick cap are dropped
                                if (notify_on[i] && fired < MAX_RESULTS) begin
                                    r.kind   = KIND_EXPIRY;
                                    r.status = STS_OK;
                                    r.slot   = 6'(i);
                                    r.last   = 1'b0;
                                    batch.push_back(r);
                                    fired++;
                                end
                            end
                        end
                    end
                    foreach (batch[k]) begin
                        r = batch[k];
                        r.last = (k == batch.size() - 1);
                        due_q.push_back(r);
                    end
                end
            end
            ACT_CREATE: begin
                r.kind   = KIND_STATUS;
                r.status = STS_NO_FREE;
                r.slot   = '0;
                r.last   = 1'b1;
                for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
                    if (!found && period_tbl[i] == 0) begin
                        found          = 1;
                        period_tbl[i]  = ivl;
                        elapsed_tbl[i] = '0;
                        r.status       = STS_OK;
                        r.slot         = 6'(i);
                    end
                end
                due_q.push_back(r);
            end
            ACT_START, ACT_STOP, ACT_ATTACH, ACT_DETACH: begin
                r.kind   = KIND_STATUS;
                r.status = STS_OK;
                r.slot   = '0;
                r.last   = 1'b1;
                if (id >= SLOT_COUNT_DEF) begin
                    r.status = STS_INVALID;
                end else begin
                    case (act)
                        ACT_START: begin
                            if (run_on[id]) begin
                                r.status = STS_RUNNING;
                            end else begin
                                run_on[id]      = 1;
                                elapsed_tbl[id] = '0;
                            end
                        end
                        ACT_STOP: begin
                            if (!run_on[id]) begin
                                r.status = STS_NOT_RUNNING;
                            end else begin
                                run_on[id] = 0;
                            end
                        end
                        ACT_ATTACH: notify_on[id] = 1;
                        default:    notify_on[id] = 0;
                    endcase
                end
                due_q.push_back(r);
            end
            default: ;  // spare codes change nothing
        endcase
    endtask

    task automatic check_result();
        timer_result_t got;
        timer_result_t want;
        got.kind   = m_tuser[0];
        got.status = status_t'(m_tdata[2:0]);
        got.slot   = m_tdata[8:3];
        got.last   = m_tlast;
        if (got.kind == KIND_EXPIRY) expiries_seen++;
        else statuses_seen++;
        if (due_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result kind %0d status %0d slot %0d last %0d",
                     $time, got.kind, got.status, got.slot, got.last);
        end else begin
            want = due_q.pop_front();
            if (got.kind !== want.kind || got.status !== want.status ||
                got.slot !== want.slot || got.last !== want.last) begin
                mismatches++;
                $display("%0t: expected kind %0d status %0d slot %0d last %0d, got kind %0d status %0d slot %0d last %0d",
                         $time, want.kind, want.status, want.slot, want.last,
                         got.kind, got.status, got.slot, got.last);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
                period_tbl[i]  = '0;
                elapsed_tbl[i] = '0;
                run_on[i]      = 0;
                notify_on[i]   = 0;
            end
            due_q.delete();
            mismatches    = 0;
            expiries_seen = 0;
            statuses_seen = 0;
        end else begin
            // a result leaving now belongs to an earlier transaction
            if (m_tvalid && m_tready) check_result();
            if (s_tvalid && s_tready)
                advance_timers(s_tuser, s_tdata[7:0], s_tdata[39:8], s_tdata[71:40]);
        end
        outstanding = due_q.size();
    end

endmodule

[test/tb_software_timer_table.sv]
`timescale 1ns / 1ps

module tb_software_timer_table;
    import stt_pkg::*;

    localparam logic [2:0] ACT_SPARE_A  = 3'd6;
    localparam logic [2:0] ACT_SPARE_B  = 3'd7;
    localparam int         RANDOM_ITEMS = 310;
    localparam int         CALM_TAIL    = 40;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [71:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    int mismatches;
    int outstanding;
    int expiries_seen;
    int statuses_seen;
    int sent  = 0;
    bit calm  = 0;

    software_timer_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    stt_checker timer_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .expiries_seen (expiries_seen),
        .statuses_seen (statuses_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("software_timer_table: mismatch");
        $finish;
    end

    // result side: random stall bursts, none in the closing stretch
    initial begin
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat (($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 25)) @(posedge aclk);
        end
    end

    task automatic issue(input logic [2:0] act, input logic [7:0] id,
                         input logic [31:0] ivl, input logic [31:0] ms);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {ms, ivl, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // mostly valid slots with notify on, so ticks keep firing events
    task automatic random_transaction(output bit counted);
        logic [2:0]  act;
        logic [7:0]  id;
        logic [31:0] ivl;
        logic [31:0] ms;
        int          pick;
        pick    = $urandom_range(0, 99);
        id      = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(8, 255))
                                              : 8'($urandom_range(0, 7));
        ivl     = $urandom;
        ms      = $urandom;
        counted = 1;
        if (pick < 45) begin
            act = ACT_TICK;
            case ($urandom_range(0, 9))
                0:       ms = '0;
                1:       ms = '1;
                2:       ms = ms;
                default: ms = $urandom_range(1, 12);
            endcase
            if (ms == 0) counted = 0;
        end else if (pick < 62) begin
            act = ACT_START;
        end else if (pick < 72) begin
            act = ACT_STOP;
        end else if (pick < 86) begin
            act = ACT_ATTACH;
        end else if (pick < 93) begin
            act = ACT_DETACH;
        end else if (pick < 97) begin
            act = ACT_CREATE;
        end else begin
            act     = ($urandom_range(0, 1) == 0) ? ACT_SPARE_A : ACT_SPARE_B;
            counted = 0;
        end
        issue(act, id, ivl, ms);
    endtask

    initial begin
        int done_cnt;
        bit counted;
        bit drained;
        done_cnt = 0;
        drained  = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        issue(ACT_TICK,   8'($urandom), $urandom, 32'd0);
        issue(ACT_START,  8'd0, $urandom, $urandom);       // interval zero never expires
        issue(ACT_CREATE, 8'($urandom), 32'd0, $urandom);  // slot stays free
        issue(ACT_STOP,   8'd0, $urandom, $urandom);
        issue(ACT_STOP,   8'd0, $urandom, $urandom);
        issue(ACT_START,  8'd255, $urandom, $urandom);
        issue(ACT_ATTACH, 8'd8, $urandom, $urandom);
        issue(ACT_SPARE_A, 8'($urandom), $urandom, $urandom);
        issue(ACT_SPARE_B, 8'($urandom), $urandom, $urandom);
        issue(ACT_CREATE, 8'($urandom), 32'd3, $urandom);
        issue(ACT_CREATE, 8'($urandom), 32'd1, $urandom);
        issue(ACT_CREATE, 8'($urandom), 32'hFFFF_FFFF, $urandom);
        issue(ACT_CREATE, 8'($urandom), 32'd5, $urandom);
        issue(ACT_CREATE, 8'($urandom), 32'd2, $urandom);
        issue(ACT_CREATE, 8'($urandom), 32'd7, $urandom);
        issue(ACT_CREATE, 8'($urandom), 32'h8000_0000, $urandom);
        issue(ACT_CREATE, 8'($urandom), 32'd10, $urandom);
        issue(ACT_CREATE, 8'($urandom), 32'd4, $urandom);  // table full
        issue(ACT_START,  8'd1, $urandom, $urandom);
        issue(ACT_START,  8'd1, $urandom, $urandom);
        issue(ACT_ATTACH, 8'd1, $urandom, $urandom);
        issue(ACT_TICK,   8'($urandom), $urandom, 32'd1);
        issue(ACT_TICK,   8'($urandom), $urandom, 32'hFFFF_FFFF);
        issue(ACT_DETACH, 8'd1, $urandom, $urandom);
        issue(ACT_DETACH, 8'd9, $urandom, $urandom);

        while (done_cnt < RANDOM_ITEMS) begin
            if (!drained && done_cnt >= RANDOM_ITEMS / 2) begin
                drained = 1;
                wait_for_results();
            end
            if (done_cnt >= RANDOM_ITEMS - CALM_TAIL) calm = 1;
            random_transaction(counted);
            if (counted) done_cnt++;
        end

        wait_for_results();
        repeat (40) @(posedge aclk);

        $display("ran %0d transactions through the timer table", sent);
        $display("checked %0d command status results and %0d expiry events",
                 statuses_seen, expiries_seen);
        if (mismatches == 0) begin
            $display("software_timer_table: match");
        end else begin
            $display("software_timer_table: mismatch");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/stt_pkg.sv
rtl/stt_alu.sv
rtl/stt_mem.sv
rtl/stt_ctrl.sv
rtl/software_timer_table.sv
test/stt_checker.sv
test/tb_software_timer_table.sv
